@@ rtl/ccw_pkg.sv @@
package ccw_pkg;

  // Field widths of the calendar registers.
  localparam int SEC_W  = 6;
  localparam int MIN_W  = 6;
  localparam int HOUR_W = 5;
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 12;
  localparam int WDAY_W = 3;

  // Calendar limits.
  localparam logic [SEC_W:0]    SEC_LAST   = 7'd59;
  localparam logic [MIN_W:0]    MIN_LAST   = 7'd59;
  localparam logic [HOUR_W:0]   HOUR_LAST  = 6'd23;
  localparam logic [MON_W:0]    MON_LAST   = 5'd12;
  localparam logic [YEAR_W-1:0] YEAR_FIRST = 12'd1900;
  localparam logic [YEAR_W-1:0] YEAR_LAST  = 12'd4095;

  // Weekday of January 1 of year 0 relative to the count that makes
  // Monday 1900-01-01 come out as Monday once its day number is added.
  localparam logic [WDAY_W-1:0] WDAY_YEAR0 = 3'd5;

  typedef enum logic [2:0] {
    W_IDLE,
    W_YEAR,
    W_MONTH,
    W_DAY,
    W_DONE
  } wday_state_t;

  // Request from the clock core to the weekday sequencer.
  typedef struct packed {
    logic              start;
    logic              take;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } wday_req_t;

  // Status back from the weekday sequencer.
  typedef struct packed {
    logic              done;
    logic              leap;
    logic [WDAY_W-1:0] weekday;
  } wday_sts_t;

  // Length of a month in days; months outside 1..12 have length zero.
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
        4'd2:                                       len = leap ? 5'd29 : 5'd28;
        default:                                    len = 5'd0;
      endcase
      return len;
    end
  endfunction

  // Month length reduced modulo 7.
  function automatic logic [WDAY_W-1:0] month_len_mod7(input logic [MON_W-1:0] m,
                                                       input logic leap);
    logic [WDAY_W-1:0] r;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 3'd3;
        4'd4, 4'd6, 4'd9, 4'd11:                    r = 3'd2;
        4'd2:                                       r = leap ? 3'd1 : 3'd0;
        default:                                    r = 3'd0;
      endcase
      return r;
    end
  endfunction

  // Day number modulo 7 by three conditional subtractions.
  function automatic logic [WDAY_W-1:0] day_mod7(input logic [DAY_W-1:0] d);
    logic [DAY_W-1:0] r;
    begin
      r = d;
      if (r >= 5'd28) r = r - 5'd28;
      if (r >= 5'd14) r = r - 5'd14;
      if (r >= 5'd7)  r = r - 5'd7;
      return r[WDAY_W-1:0];
    end
  endfunction

endpackage

@@ rtl/ccw_mod7_add.sv @@
module ccw_mod7_add (
  input  logic [ccw_pkg::WDAY_W-1:0] a,
  input  logic [ccw_pkg::WDAY_W-1:0] b,
  output logic [ccw_pkg::WDAY_W-1:0] s
);
  import ccw_pkg::*;

  logic [WDAY_W:0] sum;

  // Both operands are below 7, so one subtraction brings the sum back in range.
  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= 4'd7) begin
      s = WDAY_W'(sum - 4'd7);
    end else begin
      s = sum[WDAY_W-1:0];
    end
  end

endmodule

@@ rtl/ccw_wday.sv @@
module ccw_wday (
  input  logic               clk,
  input  logic               rst,
  input  ccw_pkg::wday_req_t req,
  output ccw_pkg::wday_sts_t sts
);
  import ccw_pkg::*;

  wday_state_t       state;
  wday_state_t       state_next;
  logic [WDAY_W-1:0] acc;
  logic [WDAY_W-1:0] acc_sum;
  logic [WDAY_W-1:0] addend;
  logic [YEAR_W-1:0] yr_cnt;
  logic [1:0]        c4;
  logic [6:0]        c100;
  logic [1:0]        c4h;
  logic [MON_W-1:0]  mon_cnt;
  logic [YEAR_W-1:0] tgt_year;
  logic [MON_W-1:0]  tgt_month;
  logic [DAY_W-1:0]  tgt_day;
  logic              leap;
  logic              year_done;
  logic              mon_done;

  // The counters track the walked year modulo 4, 100 and 400.
  assign leap      = (c4 == 2'd0) && ((c100 != 7'd0) || (c4h == 2'd0));
  assign year_done = (yr_cnt == tgt_year);
  assign mon_done  = (mon_cnt >= tgt_month);

  always_comb begin
    unique case (state)
      W_YEAR:  addend = leap ? 3'd2 : 3'd1;
      W_MONTH: addend = month_len_mod7(mon_cnt, leap);
      W_DAY:   addend = day_mod7(tgt_day);
      default: addend = 3'd0;
    endcase
  end

  ccw_mod7_add u_add (
    .a(acc),
    .b(addend),
    .s(acc_sum)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      W_IDLE:  if (req.start) state_next = W_YEAR;
      W_YEAR:  if (year_done) state_next = W_MONTH;
      W_MONTH: if (mon_done) state_next = W_DAY;
      W_DAY:   state_next = W_DONE;
      W_DONE:  if (req.take) state_next = W_IDLE;
      default: state_next = W_IDLE;
    endcase
  end

  always_comb begin
    sts.done    = (state == W_DONE);
    sts.leap    = leap;
    sts.weekday = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      W_IDLE: begin
        if (req.start) begin
          tgt_year  <= req.year;
          tgt_month <= req.month;
          tgt_day   <= req.day;
          acc       <= WDAY_YEAR0;
          yr_cnt    <= '0;
          c4        <= '0;
          c100      <= '0;
          c4h       <= '0;
          mon_cnt   <= MON_W'(1);
        end
      end
      W_YEAR: begin
        if (!year_done) begin
          acc    <= acc_sum;
          yr_cnt <= yr_cnt + 1'b1;
          c4     <= c4 + 1'b1;
          if (c100 == 7'd99) begin
            c100 <= '0;
            c4h  <= c4h + 1'b1;
          end else begin
            c100 <= c100 + 1'b1;
          end
        end
      end
      W_MONTH: begin
        if (!mon_done) begin
          acc     <= acc_sum;
          mon_cnt <= mon_cnt + 1'b1;
        end
      end
      W_DAY: begin
        acc <= acc_sum;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == W_IDLE)
    else $error("weekday start while sequencer busy");
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    (state != W_IDLE) |-> acc != 3'd7)
    else $error("weekday accumulator out of range");
  a_year_walk: assert property (@(posedge clk) disable iff (rst)
    (state == W_YEAR) |-> yr_cnt <= tgt_year)
    else $error("year walk overran target year");
`endif

endmodule

@@ rtl/calendar_clock_with_weekday.sv @@
// Channel  Direction  Handshake            Payload
// in       request    in_valid / in_ready  action, new_second .. new_year
// out      result     out_valid/out_ready  second_now .. weekday_now
//
// A request updates the date registers at its accepting edge. The weekday
// sequencer then walks the years up to the resulting year, the months up to the
// resulting month and then the day through one shared modulo-7 adder before the
// result enters the output register.
// in_ready is low from acceptance until the result enters the output register.
// A finished result waits in the sequencer while the output register is full.
// Reset (rst, synchronous) gives 00:00:00 on Monday 1900-01-01; no clearing pass.
module calendar_clock_with_weekday (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [ccw_pkg::SEC_W-1:0]   new_second,
  input  logic [ccw_pkg::MIN_W-1:0]   new_minute,
  input  logic [ccw_pkg::HOUR_W-1:0]  new_hour,
  input  logic [ccw_pkg::DAY_W-1:0]   new_day,
  input  logic [ccw_pkg::MON_W-1:0]   new_month,
  input  logic [ccw_pkg::YEAR_W-1:0]  new_year,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ccw_pkg::SEC_W-1:0]   second_now,
  output logic [ccw_pkg::MIN_W-1:0]   minute_now,
  output logic [ccw_pkg::HOUR_W-1:0]  hour_now,
  output logic [ccw_pkg::DAY_W-1:0]   day_now,
  output logic [ccw_pkg::MON_W-1:0]   month_now,
  output logic [ccw_pkg::YEAR_W-1:0]  year_now,
  output logic [ccw_pkg::WDAY_W-1:0]  weekday_now
);
  import ccw_pkg::*;

  // Current calendar state.
  logic [SEC_W-1:0]  seconds;
  logic [MIN_W-1:0]  minutes;
  logic [HOUR_W-1:0] hours;
  logic [DAY_W-1:0]  day_of_month;
  logic [MON_W-1:0]  month_of_year;
  logic [YEAR_W-1:0] calendar_year;
  // Leap flag of calendar_year, learned from the last weekday run.
  logic              year_leap;

  logic [SEC_W-1:0]  seconds_next;
  logic [MIN_W-1:0]  minutes_next;
  logic [HOUR_W-1:0] hours_next;
  logic [DAY_W-1:0]  day_of_month_next;
  logic [MON_W-1:0]  month_of_year_next;
  logic [YEAR_W-1:0] calendar_year_next;

  logic              busy;
  logic              in_acc;
  logic              take;
  wday_req_t         wreq;
  wday_sts_t         wsts;

  // Carry chain intermediates; one spare bit each so an out-of-range value
  // plus one still compares correctly.
  logic [SEC_W:0]    sec_inc;
  logic [MIN_W:0]    min_inc;
  logic [HOUR_W:0]   hour_inc;
  logic [DAY_W:0]    day_inc;
  logic [MON_W:0]    mon_inc;
  logic              sec_carry;
  logic              min_carry;
  logic              hour_carry;
  logic              day_carry;
  logic              mon_carry;
  logic [DAY_W-1:0]  cur_len;

  assign in_ready = !busy;
  assign in_acc   = in_valid && in_ready;
  // The sequencer hands its result over once the output register is free.
  assign take     = wsts.done && (!out_valid || out_ready);

  // Tick (or load on action): each carry is checked once, seconds up to months.
  always_comb begin
    sec_inc    = {1'b0, seconds} + 1'b1;
    sec_carry  = sec_inc > SEC_LAST;
    min_inc    = {1'b0, minutes} + {{MIN_W{1'b0}}, sec_carry};
    min_carry  = min_inc > MIN_LAST;
    hour_inc   = {1'b0, hours} + {{HOUR_W{1'b0}}, min_carry};
    hour_carry = hour_inc > HOUR_LAST;
    day_inc    = {1'b0, day_of_month} + {{DAY_W{1'b0}}, hour_carry};
    cur_len    = month_len(month_of_year, year_leap);
    day_carry  = day_inc > {1'b0, cur_len};
    mon_inc    = {1'b0, month_of_year} + {{MON_W{1'b0}}, day_carry};
    mon_carry  = mon_inc > MON_LAST;

    if (action) begin
      seconds_next       = new_second;
      minutes_next       = new_minute;
      hours_next         = new_hour;
      day_of_month_next  = new_day;
      month_of_year_next = new_month;
      calendar_year_next = new_year;
    end else begin
      seconds_next       = sec_carry ? '0 : sec_inc[SEC_W-1:0];
      minutes_next       = min_carry ? '0 : min_inc[MIN_W-1:0];
      hours_next         = hour_carry ? '0 : hour_inc[HOUR_W-1:0];
      day_of_month_next  = day_carry ? DAY_W'(1) : day_inc[DAY_W-1:0];
      month_of_year_next = mon_carry ? MON_W'(1) : mon_inc[MON_W-1:0];
      if (!mon_carry) begin
        calendar_year_next = calendar_year;
      end else if (calendar_year == YEAR_LAST) begin
        calendar_year_next = YEAR_FIRST;
      end else begin
        calendar_year_next = calendar_year + 1'b1;
      end
    end
  end

  // The weekday run starts on the date the request produces.
  always_comb begin
    wreq.start = in_acc;
    wreq.take  = take;
    wreq.year  = calendar_year_next;
    wreq.month = month_of_year_next;
    wreq.day   = day_of_month_next;
  end

  ccw_wday u_wday (
    .clk(clk),
    .rst(rst),
    .req(wreq),
    .sts(wsts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds       <= '0;
      minutes       <= '0;
      hours         <= '0;
      day_of_month  <= DAY_W'(1);
      month_of_year <= MON_W'(1);
      calendar_year <= YEAR_FIRST;
      year_leap     <= 1'b0;
      busy          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_acc) begin
        seconds       <= seconds_next;
        minutes       <= minutes_next;
        hours         <= hours_next;
        day_of_month  <= day_of_month_next;
        month_of_year <= month_of_year_next;
        calendar_year <= calendar_year_next;
        busy          <= 1'b1;
      end else if (take) begin
        busy <= 1'b0;
      end
      if (take) begin
        year_leap <= wsts.leap;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register: loaded only when the sequencer hands over a result.
  always_ff @(posedge clk) begin
    if (take) begin
      second_now  <= seconds;
      minute_now  <= minutes;
      hour_now    <= hours;
      day_now     <= day_of_month;
      month_now   <= month_of_year;
      year_now    <= calendar_year;
      weekday_now <= wsts.weekday;
    end
  end

`ifndef SYNTH
  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> busy)
    else $error("request accepted but block not busy");
  a_take_out: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("result handed over but output not valid");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !wsts.done)
    else $error("weekday result present while idle");
`endif

endmodule
